### rtl/pbrd_pkg.sv
// Shared types and constants for the planar bitmap run-length decoder.
// No dependencies; imported by pbrd_packer and planar_bitmap_rle_decoder.
`default_nettype none
package pbrd_pkg;

  // Record parser phase, carried between input bytes
  typedef enum logic [2:0] {
    PH_OP        = 3'd0,
    PH_PAT_COUNT = 3'd1,
    PH_REP_MARK  = 3'd2,
    PH_PAT_BYTES = 3'd3,
    PH_REP_COUNT = 3'd4,
    PH_LIT_COUNT = 3'd5,
    PH_LIT       = 3'd6,
    PH_DROP      = 3'd7
  } phase_t;

  // Sequencer state for one input byte
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_PAD,
    ST_LEND,
    ST_FLUSH,
    ST_ERR
  } fsm_state_t;

  // Source of the bytes being emitted
  typedef enum logic [1:0] {
    KIND_SOLID,
    KIND_PAT,
    KIND_LIT
  } emit_kind_t;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TRUNC    = 2'd1;
  localparam logic [1:0] STAT_AFTER_END = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LINE_BYTES     = 2'd0;
  localparam logic [1:0] REG_PLANE_COUNT    = 2'd1;
  localparam logic [1:0] REG_ROW_TOTAL      = 2'd2;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd3;

  // Record opcodes and fill colors
  localparam logic [7:0] OP_PATTERN = 8'h00;
  localparam logic [7:0] OP_LITERAL = 8'h80;
  localparam logic [7:0] REP_MARKER = 8'hff;
  localparam logic [7:0] COLOR_SET  = 8'hff;
  localparam logic [7:0] COLOR_CLR  = 8'h00;

  // Control from the sequencer to the word packer
  typedef struct packed {
    logic       push;
    logic       clr;
    logic [7:0] data;
  } pack_ctl_t;

endpackage
`default_nettype wire

### rtl/pbrd_packer.sv
// Byte packer: gathers decoded bytes into a 64-bit word, first byte in bits 7:0.
// Depends on pbrd_pkg (pack_ctl_t).
`default_nettype none
module pbrd_packer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pbrd_pkg::pack_ctl_t ctl,
  output logic [63:0]             word,
  output logic [3:0]              count,
  output logic                    full
);
  import pbrd_pkg::*;

  assign full = (count == 4'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.clr) begin
      word  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      if (full) begin
        // full word leaves this cycle; start a fresh one
        word  <= {56'd0, ctl.data};
        count <= 4'd1;
      end else begin
        word[8*count[2:0] +: 8] <= ctl.data;
        count <= count + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/planar_bitmap_rle_decoder.sv
// Top level of the planar bitmap run-length decoder: APB register file,
// record parser, byte sequencer and result register. Uses pbrd_pkg, pbrd_packer.
`default_nettype none
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | sink      | in_valid / in_stall   | code_byte
//  out     | source    | out_valid / out_stall | pixel_bytes, byte_count, plane_index,
//          |           |                       | row_index, line_end, repeat_lines,
//          |           |                       | last, status
//  cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
//  A byte that only advances the parser (opcode, counts, pattern bytes that do not
//  complete a pattern) leaves the sequencer idle. A byte that emits pixels pushes one
//  decoded byte per cycle through the shared packer unless a full word waits on a held
//  result register, then the pad byte of an odd line and the line-end transaction, or
//  a flush of a partial word when the record ends first. in_stall stays high until the
//  sequencer returns to idle. The result register frees the sequencer from the
//  consumer; out_stall only holds the sequencer when a new transaction must leave
//  while the previous one waits. Reset (synchronous, active high) restores the
//  register defaults and clears parser, position and pending output.
//
module planar_bitmap_rle_decoder #(
  parameter int MAX_LINE_BYTES = 1024,
  parameter int MAX_PLANES     = 8,
  parameter int MAX_ROWS       = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  code_byte,
  // result stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      pixel_bytes,
  output logic [3:0]       byte_count,
  output logic [2:0]       plane_index,
  output logic [11:0]      row_index,
  output logic             line_end,
  output logic [7:0]       repeat_lines,
  output logic             last,
  output logic [1:0]       status,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pbrd_pkg::*;

  localparam int PLANE_LIM = (MAX_PLANES < 8) ? MAX_PLANES : 8;
  localparam int ROW_LIM   = (MAX_ROWS < 4096) ? MAX_ROWS : 4096;

  // ---------------- configuration registers ----------------
  logic [10:0] line_bytes;
  logic [3:0]  plane_count;
  logic [12:0] row_total;
  logic [1:0]  pattern_length;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes     <= 11'd80;
      plane_count    <= 4'd1;
      row_total      <= 13'd400;
      pattern_length <= 2'd2;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LINE_BYTES:     line_bytes     <= pwdata[10:0];
        REG_PLANE_COUNT:    plane_count    <= pwdata[3:0];
        REG_ROW_TOTAL:      row_total      <= pwdata[12:0];
        REG_PATTERN_LENGTH: pattern_length <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LINE_BYTES:     prdata = {21'd0, line_bytes};
      REG_PLANE_COUNT:    prdata = {28'd0, plane_count};
      REG_ROW_TOTAL:      prdata = {19'd0, row_total};
      REG_PATTERN_LENGTH: prdata = {30'd0, pattern_length};
      default:            prdata = '0;
    endcase
  end

  // Clamp the registers into their usable ranges
  logic [10:0] lb_eff;
  logic [3:0]  planes_eff;
  logic [12:0] rows_eff;
  logic [1:0]  plen_eff;

  always_comb begin
    if (line_bytes == 11'd0)                         lb_eff = 11'd1;
    else if (32'(line_bytes) > MAX_LINE_BYTES)       lb_eff = 11'(MAX_LINE_BYTES);
    else                                             lb_eff = line_bytes;
    if (plane_count == 4'd0)                         planes_eff = 4'd1;
    else if (32'(plane_count) > PLANE_LIM)           planes_eff = 4'(PLANE_LIM);
    else                                             planes_eff = plane_count;
    if (row_total == 13'd0)                          rows_eff = 13'd1;
    else if (32'(row_total) > ROW_LIM)               rows_eff = 13'(ROW_LIM);
    else                                             rows_eff = row_total;
    if (pattern_length == 2'd0)                      plen_eff = 2'd1;
    else if (pattern_length == 2'd3)                 plen_eff = 2'd2;
    else                                             plen_eff = pattern_length;
  end

  // ---------------- decoder state ----------------
  fsm_state_t  state, state_next;
  phase_t      phase, phase_next;
  emit_kind_t  kind, kind_next;
  logic [7:0]  run_left, run_left_next;
  logic [15:0] pat_store, pat_store_next;
  logic [1:0]  pat_fill, pat_fill_next;
  logic        pat_j, pat_j_next;
  logic [10:0] line_fill, line_fill_next;
  logic [2:0]  plane_now, plane_now_next;
  logic [12:0] row_now, row_now_next;
  logic [7:0]  repeat_now, repeat_now_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic        lit_more, lit_more_next;
  logic        trunc, trunc_next;

  // packer
  pack_ctl_t   pk_ctl;
  logic [63:0] pk_word;
  logic [3:0]  pk_count;
  logic        pk_full;

  pbrd_packer u_packer (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pk_ctl),
    .word  (pk_word),
    .count (pk_count),
    .full  (pk_full)
  );

  // result register load
  logic        out_load;
  logic [63:0] ld_word;
  logic [3:0]  ld_count;
  logic [2:0]  ld_plane;
  logic [11:0] ld_row;
  logic        ld_le;
  logic [7:0]  ld_rep;
  logic        ld_last;
  logic [1:0]  ld_status;

  // ---------------- shared conditions ----------------
  logic        in_fire;
  logic        slot_free;
  logic        image_done;
  logic [10:0] line_fill_inc;
  logic        at_line_end;
  logic        pat_last_j;
  logic [7:0]  emit_byte;
  logic        emit_more;
  logic        emit_final;
  logic        emit_wait;
  logic [12:0] rows_left;
  logic [7:0]  rep_eff;
  logic [3:0]  plane_inc;
  logic [7:0]  run_dec;
  logic [7:0]  rep_code;
  logic [15:0] store_new;
  logic [1:0]  fill_new;
  logic        solid_op;

  assign in_stall      = (state != ST_IDLE);
  assign in_fire       = in_valid && !in_stall;
  assign slot_free     = !out_valid || !out_stall;
  assign image_done    = (row_now >= rows_eff);
  assign line_fill_inc = line_fill + 11'd1;
  assign at_line_end   = (line_fill_inc >= lb_eff);
  assign pat_last_j    = pat_j || (plen_eff == 2'd1);
  assign emit_wait     = pk_full && !slot_free;
  assign rows_left     = rows_eff - row_now - 13'd1;
  assign rep_eff       = (13'(repeat_now) < rows_left) ? repeat_now : rows_left[7:0];
  assign plane_inc     = {1'b0, plane_now} + 4'd1;
  assign run_dec       = run_left - 8'd1;
  assign rep_code      = (code_byte != 8'd0) ? code_byte - 8'd1 : 8'd0;
  assign store_new     = pat_store | (pat_fill[0] ? {code_byte, 8'd0} : {8'd0, code_byte});
  assign fill_new      = pat_fill + 2'd1;
  assign solid_op      = (code_byte != OP_PATTERN) && (code_byte != OP_LITERAL);

  always_comb begin
    unique case (kind)
      KIND_SOLID: begin
        emit_byte  = cur_byte;
        emit_more  = (run_left != 8'd1);
        emit_final = (run_left == 8'd1);
      end
      KIND_PAT: begin
        emit_byte  = pat_j ? pat_store[15:8] : pat_store[7:0];
        emit_more  = !((run_left == 8'd1) && pat_last_j);
        emit_final = (run_left == 8'd1) && pat_last_j;
      end
      KIND_LIT: begin
        emit_byte  = cur_byte;
        emit_more  = lit_more;
        emit_final = 1'b1;
      end
      default: begin
        emit_byte  = cur_byte;
        emit_more  = 1'b0;
        emit_final = 1'b1;
      end
    endcase
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (phase)
            PH_OP: begin
              if (image_done)    state_next = ST_ERR;
              else if (solid_op) state_next = ST_EMIT;
            end
            PH_PAT_BYTES: if (fill_new >= plen_eff) state_next = ST_EMIT;
            PH_LIT:       state_next = ST_EMIT;
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (image_done)       state_next = ST_FLUSH;
        else if (emit_wait)   state_next = ST_EMIT;
        else if (at_line_end) state_next = lb_eff[0] ? ST_PAD : ST_LEND;
        else if (emit_final)  state_next = ST_FLUSH;
      end
      ST_PAD:   if (!emit_wait) state_next = ST_LEND;
      ST_LEND:  if (slot_free) state_next = ST_IDLE;
      ST_FLUSH: if ((pk_count == 4'd0) || slot_free) state_next = ST_IDLE;
      ST_ERR:   if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: datapath and outputs ----------------
  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    run_left_next   = run_left;
    pat_store_next  = pat_store;
    pat_fill_next   = pat_fill;
    pat_j_next      = pat_j;
    line_fill_next  = line_fill;
    plane_now_next  = plane_now;
    row_now_next    = row_now;
    repeat_now_next = repeat_now;
    cur_byte_next   = cur_byte;
    lit_more_next   = lit_more;
    trunc_next      = trunc;
    pk_ctl          = '{push: 1'b0, clr: 1'b0, data: 8'd0};
    out_load        = 1'b0;
    ld_word         = pk_word;
    ld_count        = pk_count;
    ld_plane        = plane_now;
    ld_row          = row_now[11:0];
    ld_le           = 1'b0;
    ld_rep          = 8'd0;
    ld_last         = 1'b0;
    ld_status       = STAT_OK;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (phase)
            PH_OP: begin
              if (!image_done) begin
                if (code_byte == OP_PATTERN)      phase_next = PH_PAT_COUNT;
                else if (code_byte == OP_LITERAL) phase_next = PH_LIT_COUNT;
                else begin
                  kind_next     = KIND_SOLID;
                  cur_byte_next = code_byte[7] ? COLOR_SET : COLOR_CLR;
                  run_left_next = {1'b0, code_byte[6:0]};
                end
              end
            end
            PH_PAT_COUNT: begin
              if (code_byte == 8'd0) phase_next = PH_REP_MARK;
              else begin
                run_left_next  = code_byte;
                pat_fill_next  = 2'd0;
                pat_store_next = 16'd0;
                phase_next     = PH_PAT_BYTES;
              end
            end
            PH_REP_MARK: begin
              if (code_byte == REP_MARKER) phase_next = PH_REP_COUNT;
              else begin
                repeat_now_next = rep_code;
                phase_next      = PH_OP;
              end
            end
            PH_REP_COUNT: begin
              repeat_now_next = rep_code;
              phase_next      = PH_OP;
            end
            PH_PAT_BYTES: begin
              pat_store_next = store_new;
              if (fill_new >= plen_eff) begin
                // pattern complete: repeat it run_left times
                kind_next     = KIND_PAT;
                pat_j_next    = 1'b0;
                pat_fill_next = 2'd0;
                phase_next    = PH_OP;
              end else begin
                pat_fill_next = fill_new;
              end
            end
            PH_LIT_COUNT: begin
              if (code_byte == 8'd0) phase_next = PH_OP;
              else begin
                run_left_next = code_byte;
                phase_next    = PH_LIT;
              end
            end
            PH_LIT: begin
              kind_next     = KIND_LIT;
              cur_byte_next = code_byte;
              run_left_next = run_dec;
              lit_more_next = (run_dec != 8'd0);
              // a literal cut at line end or after the image drops its remaining bytes
              if ((image_done || at_line_end) && (run_dec != 8'd0)) phase_next = PH_DROP;
              else if (run_dec == 8'd0)                             phase_next = PH_OP;
            end
            PH_DROP: begin
              run_left_next = run_dec;
              if (run_dec == 8'd0) phase_next = PH_OP;
            end
            default: ;
          endcase
        end
      end

      ST_EMIT: begin
        if (image_done) begin
          // image already complete: drop the rest of the record
          if (kind != KIND_LIT) run_left_next = 8'd0;
        end else if (!emit_wait) begin
          pk_ctl   = '{push: 1'b1, clr: 1'b0, data: emit_byte};
          out_load = pk_full;
          if (at_line_end) begin
            line_fill_next = 11'd0;
            trunc_next     = emit_more;
            if (kind != KIND_LIT) run_left_next = 8'd0;
          end else begin
            line_fill_next = line_fill_inc;
            if (kind == KIND_SOLID) run_left_next = run_dec;
            else if (kind == KIND_PAT) begin
              if (pat_last_j) begin
                pat_j_next    = 1'b0;
                run_left_next = run_dec;
              end else begin
                pat_j_next = 1'b1;
              end
            end
          end
        end
      end

      ST_PAD: begin
        if (!emit_wait) begin
          pk_ctl   = '{push: 1'b1, clr: 1'b0, data: 8'd0};
          out_load = pk_full;
        end
      end

      ST_LEND: begin
        if (slot_free) begin
          out_load  = 1'b1;
          ld_le     = 1'b1;
          ld_rep    = rep_eff;
          ld_last   = 1'b1;
          ld_status = trunc ? STAT_TRUNC : STAT_OK;
          pk_ctl    = '{push: 1'b0, clr: 1'b1, data: 8'd0};
          // advance plane, then row past its replicas
          if (plane_inc >= planes_eff) begin
            plane_now_next  = 3'd0;
            row_now_next    = row_now + 13'd1 + 13'(rep_eff);
            repeat_now_next = 8'd0;
          end else begin
            plane_now_next = plane_inc[2:0];
          end
        end
      end

      ST_FLUSH: begin
        if ((pk_count != 4'd0) && slot_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          pk_ctl   = '{push: 1'b0, clr: 1'b1, data: 8'd0};
        end
      end

      ST_ERR: begin
        if (slot_free) begin
          out_load  = 1'b1;
          ld_word   = 64'd0;
          ld_count  = 4'd0;
          ld_plane  = 3'd0;
          ld_row    = 12'd0;
          ld_last   = 1'b1;
          ld_status = STAT_AFTER_END;
        end
      end

      default: ;
    endcase
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_OP;
      kind       <= KIND_SOLID;
      run_left   <= '0;
      pat_store  <= '0;
      pat_fill   <= '0;
      pat_j      <= 1'b0;
      line_fill  <= '0;
      plane_now  <= '0;
      row_now    <= '0;
      repeat_now <= '0;
      lit_more   <= 1'b0;
      trunc      <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      kind       <= kind_next;
      run_left   <= run_left_next;
      pat_store  <= pat_store_next;
      pat_fill   <= pat_fill_next;
      pat_j      <= pat_j_next;
      line_fill  <= line_fill_next;
      plane_now  <= plane_now_next;
      row_now    <= row_now_next;
      repeat_now <= repeat_now_next;
      lit_more   <= lit_more_next;
      trunc      <= trunc_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_bytes  <= ld_word;
      byte_count   <= ld_count;
      plane_index  <= ld_plane;
      row_index    <= ld_row;
      line_end     <= ld_le;
      repeat_lines <= ld_rep;
      last         <= ld_last;
      status       <= ld_status;
    end
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for planar_bitmap_rle_decoder: directed records, register
// extremes, backpressure and random image bodies, checked against a behavioral decoder.
// Depends on rtl/pbrd_pkg.sv and rtl/planar_bitmap_rle_decoder.sv.
`timescale 1ns / 1ps

module tb_top;
  import pbrd_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_LINE_BYTES = 1024;
  localparam int MAX_PLANES     = 8;
  localparam int MAX_ROWS       = 4096;
  localparam int MAX_RESULTS    = 64;
  // A quiet stretch longer than this means the block hung
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to let pass after the last expected transaction before a register write
  // or the verdict: covers a byte that is still in flight but yields nothing
  localparam int SETTLE_CYCLES  = 16;
  // Length of the long receiver hold-off that fills the block up
  localparam int HOLD_CYCLES    = 200;
  localparam int RANDOM_CODES   = 60;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef logic [7:0] code_q_t [$];

  // One decoded output transaction, field for field as on the ports
  typedef struct packed {
    logic [63:0] pixel_bytes;
    logic [3:0]  byte_count;
    logic [2:0]  plane_index;
    logic [11:0] row_index;
    logic        line_end;
    logic [7:0]  repeat_lines;
    logic        last;
    logic [1:0]  status;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid;
  logic        in_stall;
  logic [7:0]  code_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] pixel_bytes;
  logic [3:0]  byte_count;
  logic [2:0]  plane_index;
  logic [11:0] row_index;
  logic        line_end;
  logic [7:0]  repeat_lines;
  logic        last;
  logic [1:0]  status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  planar_bitmap_rle_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_byte   (code_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_bytes (pixel_bytes),
    .byte_count  (byte_count),
    .plane_index (plane_index),
    .row_index   (row_index),
    .line_end    (line_end),
    .repeat_lines(repeat_lines),
    .last        (last),
    .status      (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioral decoder: register copy, parser state and image position
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width;
  logic [3:0]  cfg_planes;
  logic [12:0] cfg_rows;
  logic [1:0]  cfg_plen;

  phase_t      dec_phase;
  logic [7:0]  run_left;
  logic [15:0] pat_bytes;
  int unsigned pat_fill;
  int unsigned line_pos;
  int unsigned plane_pos;
  int unsigned row_pos;
  int unsigned repeat_pending;

  // Word being packed for the current byte, and the words that byte produced
  logic [63:0] word_acc;
  int unsigned word_n;
  pixel_word_t step_words[$];
  // Decoded words still owed by the block, oldest first
  pixel_word_t pending_words[$];

  int unsigned gap_max;
  int unsigned codes_sent;
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          hold_request;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned width_used();
    return clamp_to(cfg_width, 1, MAX_LINE_BYTES);
  endfunction

  function automatic int unsigned planes_used();
    return clamp_to(cfg_planes, 1, (MAX_PLANES < 8) ? MAX_PLANES : 8);
  endfunction

  function automatic int unsigned rows_used();
    return clamp_to(cfg_rows, 1, (MAX_ROWS < 4096) ? MAX_ROWS : 4096);
  endfunction

  function automatic int unsigned plen_used();
    return clamp_to(cfg_plen, 1, 2);
  endfunction

  function automatic bit image_complete();
    return row_pos >= rows_used();
  endfunction

  // Row total that lies k rows past the current position
  function automatic int unsigned rows_ahead(input int unsigned k);
    return (row_pos + k > MAX_ROWS) ? MAX_ROWS : row_pos + k;
  endfunction

  function automatic void restore_defaults();
    cfg_width      = 11'd80;
    cfg_planes     = 4'd1;
    cfg_rows       = 13'd400;
    cfg_plen       = 2'd2;
    dec_phase      = PH_OP;
    run_left       = '0;
    pat_bytes      = '0;
    pat_fill       = 0;
    line_pos       = 0;
    plane_pos      = 0;
    row_pos        = 0;
    repeat_pending = 0;
  endfunction

  // Close the word being packed; the word is dropped once the per-byte cap is reached
  function automatic void close_word(input bit le, input int unsigned rep,
                                     input logic [1:0] st);
    pixel_word_t w;
    if (step_words.size() >= MAX_RESULTS) return;
    w.pixel_bytes  = word_acc;
    w.byte_count   = 4'(word_n);
    w.plane_index  = 3'(plane_pos);
    w.row_index    = 12'(row_pos);
    w.line_end     = le;
    w.repeat_lines = 8'(rep);
    w.last         = 1'b0;
    w.status       = st;
    step_words.push_back(w);
    word_acc = '0;
    word_n   = 0;
  endfunction

  function automatic void pack_byte(input logic [7:0] b);
    if (word_n >= 8) close_word(1'b0, 0, STAT_OK);
    word_acc = word_acc | (64'(b) << (8 * word_n));
    word_n++;
  endfunction

  // Place one decoded byte in the current line; returns 1 when the record must stop
  function automatic bit put_pixel(input logic [7:0] b, input bit more);
    int unsigned rows_left;
    int unsigned rep;
    if (image_complete()) return 1'b1;
    pack_byte(b);
    line_pos++;
    if (line_pos < width_used()) return 1'b0;
    // odd width: pad the line with one zero byte
    if (width_used() % 2 == 1) pack_byte(PAD_BYTE);
    // clamp replication to the rows that remain
    rows_left = rows_used() - row_pos - 1;
    rep = (repeat_pending < rows_left) ? repeat_pending : rows_left;
    close_word(1'b1, rep, more ? STAT_TRUNC : STAT_OK);
    line_pos = 0;
    plane_pos++;
    if (plane_pos >= planes_used()) begin
      plane_pos      = 0;
      row_pos        = row_pos + 1 + rep;
      repeat_pending = 0;
    end
    return 1'b1;
  endfunction

  // Advance the decoder by one accepted byte and queue the words it owes
  function automatic void decode_byte(input logic [7:0] b);
    pixel_word_t w;
    logic [7:0]  shade;
    int unsigned n;
    int unsigned plen;
    bit          stop;
    step_words.delete();
    word_acc = '0;
    word_n   = 0;
    case (dec_phase)
      PH_OP: begin
        if (image_complete()) begin
          // opcode after the last row: one all-zero word flagged as an error
          w = '0;
          w.status = STAT_AFTER_END;
          step_words.push_back(w);
        end else if (b == OP_PATTERN) begin
          dec_phase = PH_PAT_COUNT;
        end else if (b == OP_LITERAL) begin
          dec_phase = PH_LIT_COUNT;
        end else begin
          shade = b[7] ? COLOR_SET : COLOR_CLR;
          n = b[6:0];
          for (int i = 0; i < n; i++)
            if (put_pixel(shade, i + 1 < n)) break;
        end
      end
      PH_PAT_COUNT: begin
        if (b == OP_PATTERN) begin
          dec_phase = PH_REP_MARK;
        end else begin
          run_left  = b;
          pat_fill  = 0;
          pat_bytes = '0;
          dec_phase = PH_PAT_BYTES;
        end
      end
      PH_REP_MARK: begin
        if (b == REP_MARKER) begin
          dec_phase = PH_REP_COUNT;
        end else begin
          repeat_pending = (b != 0) ? b - 1 : 0;
          dec_phase = PH_OP;
        end
      end
      PH_REP_COUNT: begin
        repeat_pending = (b != 0) ? b - 1 : 0;
        dec_phase = PH_OP;
      end
      PH_PAT_BYTES: begin
        plen = plen_used();
        pat_bytes = pat_bytes | (16'(b) << (8 * (pat_fill % 2)));
        pat_fill++;
        if (pat_fill >= plen) begin
          stop = 1'b0;
          n = run_left;
          for (int i = 0; i < n && !stop; i++)
            for (int j = 0; j < plen && !stop; j++)
              stop = put_pixel(pat_bytes[8*j +: 8], !(i + 1 == n && j + 1 == plen));
          run_left  = '0;
          pat_fill  = 0;
          dec_phase = PH_OP;
        end
      end
      PH_LIT_COUNT: begin
        if (b == 8'd0) begin
          dec_phase = PH_OP;
        end else begin
          run_left  = b;
          dec_phase = PH_LIT;
        end
      end
      PH_LIT: begin
        run_left = run_left - 8'd1;
        // a literal cut off at line end swallows its remaining bytes
        if (put_pixel(b, run_left != 0) && run_left != 0) dec_phase = PH_DROP;
        else if (run_left == 0) dec_phase = PH_OP;
      end
      default: begin
        run_left = run_left - 8'd1;
        if (run_left == 0) dec_phase = PH_OP;
      end
    endcase
    // flush a partly filled word and mark the final one of this byte
    if (word_n > 0) close_word(1'b0, 0, STAT_OK);
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[k]) pending_words.push_back(step_words[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: byte sender and register writes
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap; hold it until the block takes it
  task automatic send_code(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
    codes_sent++;
  endtask

  task automatic send_codes(input code_q_t seq);
    foreach (seq[k]) send_code(seq[k]);
  endtask

  // Drop valid and wait until every owed word has arrived and the block is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then idle so writes never overlap
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINE_BYTES:     cfg_width  = val[10:0];
      REG_PLANE_COUNT:    cfg_planes = val[3:0];
      REG_ROW_TOTAL:      cfg_rows   = val[12:0];
      REG_PATTERN_LENGTH: cfg_plen   = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned width, input int unsigned planes,
                           input int unsigned rows, input int unsigned plen);
    wait_idle();
    write_reg(REG_LINE_BYTES, width);
    write_reg(REG_PLANE_COUNT, planes);
    write_reg(REG_ROW_TOTAL, rows);
    write_reg(REG_PATTERN_LENGTH, plen);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: full-count set run, cut off at the 80-byte line end
  task automatic test_default_config();
    gap_max = 7;
    send_code(8'hFF);
  endtask

  // Tiny 3-byte, 2-plane, 3-row image: truncation, pad, replication rules, end of image
  task automatic test_small_image();
    configure(3, 2, 3, 1);
    send_codes('{OP_PATTERN, 8'h05, 8'hC3});
    send_codes('{OP_LITERAL, 8'h04, 8'h01, 8'hFE, 8'h7E, 8'hEE});
    // replication with marker and count zero at the start of row 1
    send_codes('{OP_PATTERN, OP_PATTERN, REP_MARKER, 8'h00});
    send_code(8'h85);
    // replication inside the row, reaching past the image
    send_codes('{OP_PATTERN, OP_PATTERN, 8'h09});
    send_code(8'h03);
    send_code(8'h42);
  endtask

  // Registers changed between bytes of an image still in progress
  task automatic test_live_reconfig();
    configure(8, 3, rows_ahead(7), 2);
    gap_max = 0;
    send_code(8'h88);
    send_code(8'h04);
    wait_idle();
    // line already past the new width, plane past the new count
    write_reg(REG_LINE_BYTES, 2);
    write_reg(REG_PLANE_COUNT, 1);
    gap_max = 7;
    send_code(8'h02);
    send_codes('{OP_LITERAL, 8'h00});
    send_codes('{OP_LITERAL, 8'h05});
    wait_idle();
    // end the image under a literal that is still open
    write_reg(REG_ROW_TOTAL, row_pos);
    send_codes('{8'h11, 8'h22, 8'h33, 8'h44});
    send_code(8'h55);
  endtask

  // Largest and out-of-range register values
  task automatic test_register_extremes();
    configure(MAX_LINE_BYTES, MAX_PLANES, MAX_ROWS, 2);
    send_codes('{OP_PATTERN, 8'hFF, 8'h12, 8'h34});
    configure(0, 0, 8191, 0);
    send_code(8'h83);
    send_codes('{OP_PATTERN, 8'h02, 8'hA5});
    configure(2047, 15, 0, 3);
    send_code(8'h01);
  endtask

  // Hold the receiver off for a long stretch while long runs keep arriving
  task automatic test_backpressure();
    configure(64, 1, rows_ahead(8), 2);
    gap_max = 0;
    hold_request = 1'b1;
    repeat (5) send_code(8'hFF);
    send_code(8'h7F);
    gap_max = 7;
  endtask

  // One well-formed record with random content, or now and then a stray byte
  task automatic send_random_record();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_code({1'($urandom_range(0, 1)), 7'($urandom_range(1, 127))});
    end else if (pick < 50) begin
      send_code(OP_PATTERN);
      send_code(8'($urandom_range(1, 255)));
      repeat (plen_used()) send_code(8'($urandom_range(0, 255)));
    end else if (pick < 75) begin
      n = $urandom_range(0, 10);
      send_code(OP_LITERAL);
      send_code(8'(n));
      repeat (n) send_code(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_code(OP_PATTERN);
      send_code(OP_PATTERN);
      if ($urandom_range(0, 1)) send_code(REP_MARKER);
      send_code(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 4)));
    end else begin
      send_code(8'($urandom_range(0, 255)));
    end
  endtask

  // Random image bodies; every phase picks new registers and an idling pattern
  task automatic test_random_images();
    int unsigned start;
    int unsigned phase_no;
    int unsigned width;
    start    = codes_sent;
    phase_no = 0;
    while (codes_sent - start < RANDOM_CODES) begin
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_LINE_BYTES)
                                           : $urandom_range(1, 24);
      configure(width, $urandom_range(1, 4), rows_ahead($urandom_range(0, 6)),
                $urandom_range(0, 3));
      gap_max = (phase_no % 3 == 0) ? 0 : 7;
      repeat ($urandom_range(3, 6)) begin
        if (codes_sent - start < RANDOM_CODES) send_random_record();
      end
      phase_no++;
    end
    gap_max = 7;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per transaction, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned w;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = $urandom_range(0, gap_max);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted transaction with the oldest owed word
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected transaction: row %0d plane %0d status %0d",
               row_index, plane_index, status);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("pixel_bytes", want.pixel_bytes, pixel_bytes);
        check_field("byte_count", want.byte_count, byte_count);
        check_field("plane_index", want.plane_index, plane_index);
        check_field("row_index", want.row_index, row_index);
        check_field("line_end", want.line_end, line_end);
        check_field("repeat_lines", want.repeat_lines, repeat_lines);
        check_field("last", want.last, last);
        check_field("status", want.status, status);
      end
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    in_valid     <= 1'b0;
    code_byte    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    gap_max      = 7;
    codes_sent   = 0;
    error_count  = 0;
    quiet_cycles = 0;
    hold_request = 1'b0;
    restore_defaults();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_small_image();
    test_live_reconfig();
    test_register_extremes();
    test_backpressure();
    test_random_images();

    // drain everything still owed, then give the verdict
    wait_idle();
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
